@@ hdl/bwlp_pkg.sv @@
// bwlp_pkg: widths, constants and state types of the variable-cutoff butterworth low-pass
// used by the channel interfaces and the top level; no dependencies
`default_nettype none

package bwlp_pkg;

  localparam int SW      = 16;          // sample width, q1.15
  localparam int FRAC    = 30;          // coefficient fraction bits
  localparam int RATE_W  = 18;
  localparam int FC_W    = 17;
  localparam int W_W     = FRAC + 2;    // w, q2.30
  localparam int W2_W    = FRAC + 4;    // floor(w*w/2^30)
  localparam int W3_W    = FRAC + 6;    // floor(w2*w/2^30)
  localparam int WSH     = 40 - FRAC;   // drop from the q40 quotient
  localparam int S_W     = SW + 3;      // x + 3*x1 + 3*x2 + x3
  localparam int COEF_W  = 42;
  localparam int ACC_W   = 68;
  localparam int DIV_W   = 64;          // dividend and quotient bits
  localparam int REM_W   = 40;
  localparam int MR_W    = 32;
  localparam int CNT_W   = 7;

  localparam logic [42:0]         TWO_PI_Q40 = 43'h6487ED5110B;
  localparam logic [RATE_W-1:0]   RATE_RESET = 18'd48000;
  localparam logic [W_W-1:0]      W_MAX      = '1;
  localparam logic signed [SW-1:0] SMAX      = 16'sh7fff;
  localparam logic signed [SW-1:0] SMIN      = 16'sh8000;
  localparam logic signed [COEF_W-1:0] ONE   = 42'sd1073741824;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SETUP,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    PH_FCP,
    PH_WDIV,
    PH_W2,
    PH_W3,
    PH_COEF,
    PH_P0,
    PH_P1,
    PH_P2,
    PH_P3,
    PH_NEG,
    PH_RND,
    PH_QDIV
  } phase_e;

endpackage

`default_nettype wire

@@ hdl/bwlp_in_if.sv @@
// bwlp_in_if: input channel, one sample and its cutoff per transaction
// depends on bwlp_pkg
`default_nettype none

interface bwlp_in_if
  import bwlp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [SW-1:0]    sample_in;
  logic        [FC_W-1:0]  cutoff_hz;

  modport source (output valid, sample_in, cutoff_hz, input ready);
  modport sink   (input valid, sample_in, cutoff_hz, output ready);
endinterface

`default_nettype wire

@@ hdl/bwlp_out_if.sv @@
// bwlp_out_if: output channel, one filtered sample per transaction
// depends on bwlp_pkg
`default_nettype none

interface bwlp_out_if
  import bwlp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

@@ hdl/butterworth_lowpass_variable_cutoff.sv @@
// butterworth_lowpass_variable_cutoff: third-order bilinear low-pass, cutoff per sample
// depends on bwlp_pkg, bwlp_in_if, bwlp_out_if
//
// usage:
//   in_i carries one q1.15 sample and a cutoff in hz per transaction; out_o returns
//   one saturated q1.15 sample for each. cfg_we_i/cfg_wdata_i write the sample rate
//   (reset value 48000); write it only while the block is idle.
//   the bit-serial shift-add multiplier and the one-bit-per-cycle restoring divider
//   share one 68-bit adder under a sequencer; coefficients and the input sum come
//   from fixed shift-add logic in the coefficient setup step.
//   the time from an input transaction to its result goes to the serial multiplies,
//   two 64-step divisions (one when the sample rate is zero) and the setup steps
//   between them. in_i.ready is high only while idle, so one sample is in flight
//   at a time.
//   if the receiver stalls, the result is held in the output register and no new
//   sample is taken until it is accepted.
//   reset clears the three past inputs and outputs and returns to idle.
`default_nettype none

module butterworth_lowpass_variable_cutoff
  import bwlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  bwlp_in_if.sink           in_i,
  bwlp_out_if.source        out_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [RATE_W-1:0]        rate_q;
  logic signed [SW-1:0]     x_q, x_d, x1_q, x1_d, x2_q, x2_d, x3_q, x3_d;
  logic signed [SW-1:0]     y1_q, y1_d, y2_q, y2_d, y3_q, y3_d, out_q, out_d;
  logic [W_W-1:0]           w_q, w_d;
  logic [W2_W-1:0]          w2_q, w2_d;
  logic [W3_W-1:0]          w3_q, w3_d;
  logic signed [COEF_W-1:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic signed [S_W-1:0]    s_q, s_d;
  logic [ACC_W-1:0]         acc_q, acc_d, mc_q, mc_d;
  logic [MR_W-1:0]          mr_q, mr_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     sgn_q, sgn_d, neg_q, neg_d;
  logic [REM_W-1:0]         rem_q, rem_d, div_q, div_d;

  // shared adder
  logic [ACC_W-1:0] add_a, add_b, add_sum;
  logic             add_ci;
  assign add_sum = add_a + add_b + ACC_W'(add_ci);

  logic last;
  assign last = (cnt_q == CNT_W'(1));

  // restoring divider step, subtraction done on the shared adder
  logic [REM_W:0] rem_sh, rem_sub;
  logic           rem_ge;
  assign rem_sh  = {rem_q, acc_q[DIV_W-1]};
  assign rem_sub = add_sum[REM_W:0];
  assign rem_ge  = !rem_sub[REM_W];

  // w from the q40 quotient, saturated to q2.30
  logic [W_W-1:0] w_sat;
  assign w_sat = (|acc_q[DIV_W-1:WSH+W_W]) ? W_MAX : acc_q[WSH+W_W-1:WSH];

  // coefficients and input sum
  logic signed [COEF_W-1:0] we, w2e, w3e, a_c, b_c, c_c, d_c;
  assign we  = COEF_W'(w_q);
  assign w2e = COEF_W'(w2_q);
  assign w3e = COEF_W'(w3_q);
  assign a_c = (ONE <<< 3) + (we <<< 3) + (w2e <<< 2) + w3e;
  assign b_c = (ONE <<< 4) + (ONE <<< 3) + (we <<< 3) - (w2e <<< 2) - (w3e <<< 1) - w3e;
  assign c_c = (we <<< 3) + (w2e <<< 2) - (w3e <<< 1) - w3e - (ONE <<< 4) - (ONE <<< 3);
  assign d_c = (ONE <<< 3) - (we <<< 3) + (w2e <<< 2) - w3e;

  logic signed [S_W-1:0] xe, x12, s_c;
  assign xe  = S_W'(x_q);
  assign x12 = S_W'(x1_q) + S_W'(x2_q);
  assign s_c = xe + (x12 <<< 1) + x12 + S_W'(x3_q);

  // output saturation
  logic [DIV_W-1:0]     qv;
  logic signed [SW-1:0] y_c;
  assign qv = acc_q[DIV_W-1:0];
  always_comb begin
    if (neg_q) begin
      y_c = (qv > DIV_W'({1'b0, SMIN})) ? SMIN : -$signed(qv[SW-1:0]);
    end else begin
      y_c = (qv > DIV_W'(SMAX)) ? SMAX : $signed(qv[SW-1:0]);
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = (state_q == S_OUT);
  assign out_o.sample_out = out_q;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    x_d = x_q; x1_d = x1_q; x2_d = x2_q; x3_d = x3_q;
    y1_d = y1_q; y2_d = y2_q; y3_d = y3_q; out_d = out_q;
    w_d = w_q; w2_d = w2_q; w3_d = w3_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; s_d = s_q;
    acc_d = acc_q; mc_d = mc_q; mr_d = mr_q; cnt_d = cnt_q;
    sgn_d = sgn_q; neg_d = neg_q; rem_d = rem_q; div_d = div_q;
    add_a  = acc_q;
    add_b  = '0;
    add_ci = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x_d     = in_i.sample_in;
          acc_d   = '0;
          mc_d    = ACC_W'(TWO_PI_Q40);
          mr_d    = MR_W'(in_i.cutoff_hz);
          cnt_d   = CNT_W'(FC_W);
          sgn_d   = 1'b0;
          phase_d = PH_FCP;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // two's complement multiplier: the sign bit weighs negative
        if (mr_q[0]) begin
          add_b  = (last && sgn_q) ? ~mc_q : mc_q;
          add_ci = last && sgn_q;
        end
        acc_d = add_sum;
        mc_d  = mc_q << 1;
        mr_d  = mr_q >> 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (last) state_d = S_SETUP;
      end
      S_DIV: begin
        add_a  = ACC_W'(rem_sh);
        add_b  = ~ACC_W'({1'b0, div_q});
        add_ci = 1'b1;
        rem_d = rem_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        acc_d = {acc_q[ACC_W-2:0], rem_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (last) state_d = S_SETUP;
      end
      S_SETUP: begin
        unique case (phase_q)
          PH_FCP: begin
            phase_d = PH_WDIV;
            if (rate_q == '0) begin
              acc_d = '1;  // saturates w
            end else begin
              rem_d   = '0;
              div_d   = REM_W'(rate_q);
              cnt_d   = CNT_W'(DIV_W);
              state_d = S_DIV;
            end
          end
          PH_WDIV: begin
            w_d     = w_sat;
            acc_d   = '0;
            mc_d    = ACC_W'(w_sat);
            mr_d    = MR_W'(w_sat);
            cnt_d   = CNT_W'(W_W);
            sgn_d   = 1'b0;
            phase_d = PH_W2;
            state_d = S_MUL;
          end
          PH_W2: begin
            w2_d    = acc_q[FRAC+W2_W-1:FRAC];
            acc_d   = '0;
            mc_d    = ACC_W'(acc_q[FRAC+W2_W-1:FRAC]);
            mr_d    = MR_W'(w_q);
            cnt_d   = CNT_W'(W_W);
            phase_d = PH_W3;
            state_d = S_MUL;
          end
          PH_W3: begin
            w3_d    = acc_q[FRAC+W3_W-1:FRAC];
            phase_d = PH_COEF;
          end
          PH_COEF: begin
            a_d = a_c; b_d = b_c; c_d = c_c; d_d = d_c; s_d = s_c;
            phase_d = PH_P0;
          end
          PH_P0: begin
            acc_d   = '0;
            mc_d    = ACC_W'(w3_q);
            mr_d    = MR_W'(s_q);
            cnt_d   = CNT_W'(S_W);
            sgn_d   = 1'b1;
            phase_d = PH_P1;
            state_d = S_MUL;
          end
          PH_P1: begin
            mc_d    = ACC_W'(b_q);
            mr_d    = MR_W'(y1_q);
            cnt_d   = CNT_W'(SW);
            phase_d = PH_P2;
            state_d = S_MUL;
          end
          PH_P2: begin
            mc_d    = ACC_W'(c_q);
            mr_d    = MR_W'(y2_q);
            cnt_d   = CNT_W'(SW);
            phase_d = PH_P3;
            state_d = S_MUL;
          end
          PH_P3: begin
            mc_d    = ACC_W'(d_q);
            mr_d    = MR_W'(y3_q);
            cnt_d   = CNT_W'(SW);
            phase_d = PH_NEG;
            state_d = S_MUL;
          end
          PH_NEG: begin
            neg_d = acc_q[ACC_W-1];
            if (acc_q[ACC_W-1]) begin
              add_a  = '0;
              add_b  = ~acc_q;
              add_ci = 1'b1;
            end
            acc_d   = add_sum;
            phase_d = PH_RND;
          end
          PH_RND: begin
            // round half away from zero on the magnitude
            add_b   = ACC_W'(a_q[COEF_W-1:1]);
            acc_d   = add_sum;
            rem_d   = '0;
            div_d   = a_q[REM_W-1:0];
            cnt_d   = CNT_W'(DIV_W);
            phase_d = PH_QDIV;
            state_d = S_DIV;
          end
          PH_QDIV: begin
            out_d = y_c;
            x3_d = x2_q; x2_d = x1_q; x1_d = x_q;
            y3_d = y2_q; y2_d = y1_q; y1_d = y_c;
            state_d = S_OUT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_FCP;
      rate_q  <= RATE_RESET;
      x1_q <= '0; x2_q <= '0; x3_q <= '0;
      y1_q <= '0; y2_q <= '0; y3_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (cfg_we_i) rate_q <= cfg_wdata_i;
      x1_q <= x1_d; x2_q <= x2_d; x3_q <= x3_d;
      y1_q <= y1_d; y2_q <= y2_d; y3_q <= y3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; out_q <= out_d;
    w_q <= w_d; w2_q <= w2_d; w3_q <= w3_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; s_q <= s_d;
    acc_q <= acc_d; mc_q <= mc_d; mr_q <= mr_d; cnt_q <= cnt_d;
    sgn_q <= sgn_d; neg_q <= neg_d; rem_q <= rem_d; div_q <= div_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready) else $error("input ready while result pending");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_MUL && phase_q == PH_FCP))
    else $error("sequencer did not start on transaction");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < div_q)) else $error("divider remainder out of range");

  a_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (y1_q == out_o.sample_out)) else $error("output history mismatch");

endmodule

`default_nettype wire

@@ verif/bwlp_check.sv @@
// bwlp_check: watches the sample channels and the rate register of the low-pass,
// predicts every filtered sample and compares; depends on bwlp_pkg and the channel interfaces
`default_nettype none

module bwlp_check
  import bwlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  bwlp_in_if                mon_in,
  bwlp_out_if               mon_out,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [RATE_W-1:0]    rate_q;
  logic signed [SW-1:0] x_hist [3];
  logic signed [SW-1:0] y_hist [3];
  logic signed [SW-1:0] expected_samples [$];

  assign pending_o = expected_samples.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors_o++;
  endtask

  // next output of the filter for one sample and cutoff, from the current history
  function automatic logic signed [SW-1:0] filter_next(input logic signed [SW-1:0] x,
                                                       input logic [FC_W-1:0] fc);
    logic [63:0]          wq;
    logic [127:0]         wu, w2u, w3u;
    logic signed [127:0]  w, w2, w3, one, a, b, c, d;
    logic signed [127:0]  xs, x1, x2, x3, y1, y2, y3, s, acc, mag, q;
    logic signed [SW-1:0] y;
    one = 128'sd1 <<< FRAC;
    if (rate_q == '0) begin
      wu = 128'(W_MAX);
    end else begin
      wq = (64'(fc) * 64'(TWO_PI_Q40)) / 64'(rate_q);
      wu = 128'(wq >> WSH);
      if (wu > 128'(W_MAX)) wu = 128'(W_MAX);
    end
    w2u = (wu * wu) >> FRAC;
    w3u = (w2u * wu) >> FRAC;
    w  = wu;
    w2 = w2u;
    w3 = w3u;
    a = 8 * one + 8 * w + 4 * w2 + w3;
    b = 24 * one + 8 * w - 4 * w2 - 3 * w3;
    c = -24 * one + 8 * w + 4 * w2 - 3 * w3;
    d = 8 * one - 8 * w + 4 * w2 - w3;
    xs = x;
    x1 = x_hist[0];
    x2 = x_hist[1];
    x3 = x_hist[2];
    y1 = y_hist[0];
    y2 = y_hist[1];
    y3 = y_hist[2];
    s = xs + 3 * (x1 + x2) + x3;
    acc = w3 * s + b * y1 + c * y2 + d * y3;
    mag = (acc < 0) ? -acc : acc;
    // round half away from zero on the magnitude
    mag = mag + (a >>> 1);
    q = mag / a;
    if (acc < 0) y = (q > 128'sd32768) ? SMIN : SW'(-q);
    else         y = (q > 128'sd32767) ? SMAX : SW'(q);
    return y;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SW-1:0] y;
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
      for (int i = 0; i < 3; i++) begin
        x_hist[i] <= '0;
        y_hist[i] <= '0;
      end
      expected_samples.delete();
    end else begin
      if (cfg_we_i) rate_q <= cfg_wdata_i;
      if (mon_in.valid && mon_in.ready) begin
        y = filter_next(mon_in.sample_in, mon_in.cutoff_hz);
        expected_samples.push_back(y);
        x_hist[2] <= x_hist[1];
        x_hist[1] <= x_hist[0];
        x_hist[0] <= mon_in.sample_in;
        y_hist[2] <= y_hist[1];
        y_hist[1] <= y_hist[0];
        y_hist[0] <= y;
      end
      if (mon_out.valid && mon_out.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", mon_out.sample_out));
        end else begin
          y = expected_samples.pop_front();
          if (mon_out.sample_out !== y)
            report_mismatch($sformatf("sample_out %0d, predicted %0d", mon_out.sample_out, y));
        end
      end
    end
  end
endmodule

`default_nettype wire

@@ verif/butterworth_lowpass_variable_cutoff_tb.sv @@
// butterworth_lowpass_variable_cutoff_tb: drives samples, cutoffs and sample rates into the
// low-pass and gives the verdict; depends on bwlp_pkg, the channel interfaces and bwlp_check
`default_nettype none

module butterworth_lowpass_variable_cutoff_tb
  import bwlp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_ITEMS = 220;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [RATE_W-1:0] cfg_wdata_i = '0;
  int                tx_idle = 0;
  int                rx_idle = 0;
  int                hold_left = 0;
  int                hold_req = 0;
  int                hold_seen = 0;
  int                quiet_cycles = 0;
  int                errors;
  int                pending;
  logic [RATE_W-1:0] cur_rate = RATE_RESET;

  bwlp_in_if  in_ch ();
  bwlp_out_if out_ch ();

  butterworth_lowpass_variable_cutoff dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  bwlp_check checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mon_in      (in_ch),
    .mon_out     (out_ch),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.cutoff_hz = '0;
    out_ch.ready    = 1'b0;
  end

  // receiver, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SW-1:0] x, input logic [FC_W-1:0] fc);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    in_ch.cutoff_hz <= fc;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // block is idle once every sample is back; then the rate may change
  task automatic set_rate(input logic [RATE_W-1:0] rate);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    cur_rate     = rate;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= RATE_W'($urandom());
    @(posedge clk_i);
  endtask

  function automatic logic [FC_W-1:0] pick_cutoff();
    int sel;
    int top;
    sel = $urandom_range(99);
    top = (cur_rate == '0 || cur_rate / 2 > 96000) ? 96000 : cur_rate / 2;
    if (sel < 60) return FC_W'($urandom_range(top, 0));
    if (sel < 80) return FC_W'($urandom_range(96000, 0));
    if (sel < 90) return FC_W'($urandom());
    return FC_W'($urandom_range(2000, 0));
  endfunction

  task automatic random_phase(input int count);
    logic signed [SW-1:0] x;
    logic [FC_W-1:0]      fc;
    x  = '0;
    fc = pick_cutoff();
    for (int i = 0; i < count; i++) begin
      // steps held for a while, or fresh noise
      if ($urandom_range(99) < 70) x = SW'($urandom());
      if ($urandom_range(99) < 40) fc = pick_cutoff();
      send_sample(x, fc);
    end
  endtask

  initial begin
    logic [RATE_W-1:0] rates [6];
    rates[0] = RATE_RESET;
    rates[1] = 18'd8000;
    rates[2] = 18'd192000;
    rates[3] = '0;
    rates[4] = '1;
    rates[5] = RATE_W'($urandom_range(192000, 8000));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle = 17;
    rx_idle = 87;
    // directed: extremes, zero cutoff, saturating cutoff, overflow
    send_sample(SMAX, 17'd96000);
    send_sample(SMAX, 17'd96000);
    send_sample(SMIN, 17'd96000);
    send_sample(SMIN, 17'd131071);
    send_sample(SMAX, 17'd131071);
    send_sample(SMIN, 17'd131071);
    send_sample(SMAX, 17'd0);
    send_sample(SMIN, 17'd0);
    send_sample(16'sd0, 17'd0);
    for (int i = 0; i < 6; i++) send_sample(SMAX, 17'd20000);
    for (int i = 0; i < 4; i++) send_sample(16'sd0, 17'd1);
    send_sample(-16'sd1, 17'd65535);
    send_sample(16'sd1, 17'd1000);
    send_sample(16'sh5555, 17'h0aaaa);
    send_sample(16'shaaaa, 17'h15555);

    for (int p = 0; p < 6; p++) begin
      if (p != 0) set_rate(rates[p]);
      if (p >= 2) begin
        tx_idle = (p >= 4) ? 0 : 87;
        rx_idle = (p >= 4) ? 0 : 17;
      end
      if (p == 1 || p == 4) hold_req++;
      random_phase(PHASE_ITEMS);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire
